[sv/bir_pkg.sv]
// Shared constants, payload types and controller/datapath interface types.
package bir_pkg;

    // Frame store geometry
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);

    // Field and register widths
    localparam int COORD_W = 9;
    localparam int PIX_W   = 8;
    localparam int DIM_W   = 10;
    localparam int SCALE_W = 26;
    localparam int CFG_W   = 26;
    localparam int IDX_W   = 3;
    localparam int POS_W   = COORD_W + SCALE_W;
    localparam int FRAC_W  = 8;
    localparam int WGT_W   = 2 * FRAC_W + 1;
    localparam int PROD_W  = WGT_W + PIX_W;
    localparam int ACC_W   = PROD_W;

    // Operation codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_SRC_W   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SRC_H   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_OUT_W   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_OUT_H   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SCALE_X = 3'd4;
    localparam logic [IDX_W-1:0] CFG_SCALE_Y = 3'd5;

    // Register reset values
    localparam logic [DIM_W-1:0]   RST_DIM   = 10'd512;
    localparam logic [SCALE_W-1:0] RST_SCALE = 26'd65536;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             out_of_range;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;      // capture the incoming transaction
        logic       wr;        // write captured pixel to the frame store
        logic       req;       // form source positions, latch range flag
        logic       idx;       // form neighbour indexes and weights
        logic       rd;        // read one neighbour
        logic [1:0] rd_sel;    // which neighbour
        logic       res_load;  // load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_req;
        logic oor;
    } t_sts;

endpackage

[sv/bir_ctrl.sv]
// Sequencing state machine and output valid for the bilinear resizer.
module bir_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  bir_pkg::t_sts i_sts,
    output bir_pkg::t_cmd o_cmd
);
    import bir_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INDEX,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_DR0,
        S_DR1,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    // Output register can take a result this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (!i_sts.is_req)  n_state = S_IDLE;
                else if (i_sts.oor) n_state = S_RESULT;
                else                n_state = S_INDEX;
            end
            S_INDEX:  n_state = S_RD0;
            S_RD0:    n_state = S_RD1;
            S_RD1:    n_state = S_RD2;
            S_RD2:    n_state = S_RD3;
            S_RD3:    n_state = S_DR0;
            S_DR0:    n_state = S_DR1;
            S_DR1:    n_state = S_RESULT;
            S_RESULT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.wr       = (r_state == S_DECODE) && !i_sts.is_req;
        o_cmd.req      = (r_state == S_DECODE) && i_sts.is_req;
        o_cmd.idx      = (r_state == S_INDEX);
        o_cmd.res_load = (r_state == S_RESULT) && w_out_free;
        case (r_state)
            S_RD0:   begin o_cmd.rd = 1'b1; o_cmd.rd_sel = 2'd0; end
            S_RD1:   begin o_cmd.rd = 1'b1; o_cmd.rd_sel = 2'd1; end
            S_RD2:   begin o_cmd.rd = 1'b1; o_cmd.rd_sel = 2'd2; end
            S_RD3:   begin o_cmd.rd = 1'b1; o_cmd.rd_sel = 2'd3; end
            default: begin o_cmd.rd = 1'b0; o_cmd.rd_sel = 2'd0; end
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load)  r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[sv/bir_dp.sv]
// Datapath: configuration registers, frame store, position maths and blend.
module bir_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bir_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [bir_pkg::CFG_W-1:0]     i_cfg_data,
    input  bir_pkg::t_in_item             i_in_data,
    input  bir_pkg::t_cmd                 i_cmd,
    output bir_pkg::t_sts                 o_sts,
    output bir_pkg::t_out_item            o_out_data
);
    import bir_pkg::*;

    // Configuration
    logic [DIM_W-1:0]   r_src_w, r_src_h, r_out_w, r_out_h;
    logic [SCALE_W-1:0] r_scale_x, r_scale_y;

    // Captured transaction and request state
    t_in_item           r_item;
    logic [POS_W-1:0]   r_sx, r_sy;
    logic               r_oor;
    logic [COL_W-1:0]   r_c0, r_c1;
    logic [ROW_W-1:0]   r_r0, r_r1;
    logic [WGT_W-1:0]   r_w [4];

    // Frame store and blend pipeline
    logic [PIX_W-1:0]   r_frame [DEPTH];
    logic [PIX_W-1:0]   r_pix;
    logic               r_rd_v;
    logic [1:0]         r_sel;
    logic [PROD_W-1:0]  r_prod;
    logic               r_prod_v;
    logic [ACC_W-1:0]   r_acc;
    t_out_item          r_res;

    logic               w_oor;
    logic [COL_W-1:0]   w_lastc;
    logic [ROW_W-1:0]   w_lastr;
    logic [POS_W-17:0]  w_ix, w_iy;
    logic [POS_W-16:0]  w_ix1, w_iy1;
    logic [FRAC_W-1:0]  w_fx, w_fy;
    logic [FRAC_W:0]    w_wx0, w_wy0;
    logic               w_in_store;
    logic [COL_W-1:0]   w_rd_col;
    logic [ROW_W-1:0]   w_rd_row;
    logic [ADDR_W-1:0]  w_addr;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= RST_DIM;
            r_src_h   <= RST_DIM;
            r_out_w   <= RST_DIM;
            r_out_h   <= RST_DIM;
            r_scale_x <= RST_SCALE;
            r_scale_y <= RST_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_W:   r_src_w   <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_H:   r_src_h   <= i_cfg_data[DIM_W-1:0];
                CFG_OUT_W:   r_out_w   <= i_cfg_data[DIM_W-1:0];
                CFG_OUT_H:   r_out_h   <= i_cfg_data[DIM_W-1:0];
                CFG_SCALE_X: r_scale_x <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y: r_scale_y <= i_cfg_data[SCALE_W-1:0];
                default:     ;
            endcase
        end
    end

    // Last usable source column and row (zero counts as one, oversize saturates)
    always_comb begin
        if (r_src_w == '0)                   w_lastc = '0;
        else if (32'(r_src_w) > MAX_WIDTH)   w_lastc = COL_W'(MAX_WIDTH - 1);
        else                                 w_lastc = COL_W'(r_src_w - 1'b1);
        if (r_src_h == '0)                   w_lastr = '0;
        else if (32'(r_src_h) > MAX_HEIGHT)  w_lastr = ROW_W'(MAX_HEIGHT - 1);
        else                                 w_lastr = ROW_W'(r_src_h - 1'b1);
    end

    // Status for the controller
    assign w_oor        = ({1'b0, r_item.column} >= r_out_w) || ({1'b0, r_item.row} >= r_out_h);
    assign o_sts.is_req = (r_item.op == OP_REQUEST);
    assign o_sts.oor    = w_oor;

    // Transaction capture and source position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in_data;
        if (i_cmd.req) begin
            r_sx  <= POS_W'(r_item.column) * POS_W'(r_scale_x);
            r_sy  <= POS_W'(r_item.row) * POS_W'(r_scale_y);
            r_oor <= w_oor;
        end
    end

    // Integer and fractional parts
    assign w_ix  = r_sx[POS_W-1:16];
    assign w_iy  = r_sy[POS_W-1:16];
    assign w_ix1 = {1'b0, w_ix} + 1'b1;
    assign w_iy1 = {1'b0, w_iy} + 1'b1;
    assign w_fx  = r_sx[15:8];
    assign w_fy  = r_sy[15:8];
    assign w_wx0 = 9'd256 - {1'b0, w_fx};
    assign w_wy0 = 9'd256 - {1'b0, w_fy};

    // Clamped neighbour indexes and the four blend weights
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx) begin
            r_c0 <= (32'(w_ix)  > 32'(w_lastc)) ? w_lastc : COL_W'(w_ix);
            r_c1 <= (32'(w_ix1) > 32'(w_lastc)) ? w_lastc : COL_W'(w_ix1);
            r_r0 <= (32'(w_iy)  > 32'(w_lastr)) ? w_lastr : ROW_W'(w_iy);
            r_r1 <= (32'(w_iy1) > 32'(w_lastr)) ? w_lastr : ROW_W'(w_iy1);
            r_w[0] <= WGT_W'(w_wx0) * WGT_W'(w_wy0);
            r_w[1] <= WGT_W'(w_fx) * WGT_W'(w_wy0);
            r_w[2] <= WGT_W'(w_wx0) * WGT_W'(w_fy);
            r_w[3] <= WGT_W'(w_fx) * WGT_W'(w_fy);
        end
    end

    // Single store address: write location or selected neighbour
    assign w_in_store = (32'(r_item.column) < MAX_WIDTH) && (32'(r_item.row) < MAX_HEIGHT);
    assign w_rd_col   = i_cmd.rd_sel[0] ? r_c1 : r_c0;
    assign w_rd_row   = i_cmd.rd_sel[1] ? r_r1 : r_r0;
    always_comb begin
        if (i_cmd.wr)
            w_addr = ADDR_W'(32'(r_item.row) * MAX_WIDTH + 32'(r_item.column));
        else
            w_addr = ADDR_W'(32'(w_rd_row) * MAX_WIDTH + 32'(w_rd_col));
    end

    // Frame store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_in_store) r_frame[w_addr] <= r_item.pixel_in;
        if (i_cmd.rd)               r_pix <= r_frame[w_addr];
    end

    // Blend pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.rd;
            r_prod_v <= r_rd_v;
        end
    end

    // Weighted product and accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_sel <= i_cmd.rd_sel;
        if (r_rd_v)   r_prod <= PROD_W'(r_w[r_sel]) * PROD_W'(r_pix);
        if (i_cmd.idx)     r_acc <= '0;
        else if (r_prod_v) r_acc <= r_acc + r_prod;
    end

    // Result register; the sum of weights is 2^16, so bits 23:16 hold the pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res.out_of_range <= r_oor;
            r_res.pixel_out    <= r_oor ? '0 : r_acc[16 +: PIX_W];
        end
    end

    assign o_out_data = r_res;

endmodule

[sv/bilinear_image_resize.sv]
// Top level of the bilinear image resizer: controller plus datapath.
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_stall    i_in_data  (op, column, row, pixel_in)
//  output   out        o_out_valid / i_out_stall  o_out_data (pixel_out, out_of_range)
//  config   in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A pixel write lands in the store in the cycle after acceptance; the next transaction can be
// accepted once the controller has passed from decode back to idle. An in-range request goes
// through decode, index, four single-port neighbour reads, two multiply-accumulate stages and
// result, then loads the result register; an out-of-range request skips straight to result.
// Reset restores the configuration registers; frame contents are not cleared.
// A stalled result holds in the output register; a further result waits until it is taken.
module bilinear_image_resize (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bir_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bir_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [bir_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [bir_pkg::CFG_W-1:0]     i_cfg_data
);
    import bir_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    bir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath
    bir_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // An accepted transaction blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // Out-of-range results carry a zero pixel
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_of_range) |-> (o_out_data.pixel_out == '0))
        else $error("out-of-range result with non-zero pixel");

    // A pixel write never raises a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.op == OP_WRITE)
            |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result produced by a pixel write");

    // Neighbour reads only while the input is blocked
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd |-> o_in_stall)
        else $error("frame read outside a request");
`endif

endmodule

[test/tb_bilinear_image_resize.sv]
// Self-checking testbench for the bilinear image resizer: directed and random pixel traffic.
`timescale 1ns / 100ps

module tb_bilinear_image_resize;
    import bir_pkg::*;

    localparam int LONG_HOLD   = 300;   // cycles of receiver back-pressure
    localparam int SETTLE      = 16;    // covers the pixel write latency and a margin
    localparam int IDLE_LIMIT  = 3000;  // cycles without any transaction
    localparam int ITEM_TARGET = 1900;
    localparam int PHASE_ITEMS = 150;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_item         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_data;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    // Register shadow, kept in step with every configuration write
    logic [DIM_W-1:0]   src_w   = RST_DIM;
    logic [DIM_W-1:0]   src_h   = RST_DIM;
    logic [DIM_W-1:0]   out_w   = RST_DIM;
    logic [DIM_W-1:0]   out_h   = RST_DIM;
    logic [SCALE_W-1:0] scale_x = RST_SCALE;
    logic [SCALE_W-1:0] scale_y = RST_SCALE;

    // Frame contents as written by accepted transactions, and what the generator has queued
    logic [PIX_W-1:0] frame_model [DEPTH];
    bit               written_map [DEPTH];

    t_in_item  ops_to_send     [$];
    t_out_item expected_pixels [$];

    int send_gap_max   = 4;
    int recv_gap_max   = 4;
    int send_gap       = 0;
    int recv_gap       = 0;
    int hold_left      = 0;
    bit want_long_hold = 1'b0;
    bit long_hold_done = 1'b0;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int items_queued   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bilinear_image_resize DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Zero counts as one, anything above the store size counts as the store size
    function automatic int unsigned effective_size(logic [DIM_W-1:0] v, int unsigned limit);
        if (v == '0) return 1;
        if (32'(v) > limit) return limit;
        return 32'(v);
    endfunction

    // Source position of an output pixel: clamped neighbour indexes and 8-bit fractions
    function automatic void locate_neighbours(input logic [COORD_W-1:0] col, row,
                                              output int unsigned c0, c1, r0, r1, fx, fy);
        logic [POS_W-1:0] sx, sy;
        int unsigned      ix, iy, lastc, lastr;
        lastc = effective_size(src_w, MAX_WIDTH) - 1;
        lastr = effective_size(src_h, MAX_HEIGHT) - 1;
        sx = POS_W'(col) * POS_W'(scale_x);
        sy = POS_W'(row) * POS_W'(scale_y);
        ix = 32'(sx[POS_W-1:16]);
        iy = 32'(sy[POS_W-1:16]);
        fx = 32'(sx[15:8]);
        fy = 32'(sy[15:8]);
        c0 = (ix > lastc) ? lastc : ix;
        c1 = (ix + 1 > lastc) ? lastc : ix + 1;
        r0 = (iy > lastr) ? lastr : iy;
        r1 = (iy + 1 > lastr) ? lastr : iy + 1;
    endfunction

    // Expected result of one output pixel request
    function automatic t_out_item interpolate(t_in_item req);
        t_out_item   res;
        int unsigned c0, c1, r0, r1, fx, fy, sum;
        res = '0;
        if ({1'b0, req.column} >= out_w || {1'b0, req.row} >= out_h) begin
            res.out_of_range = 1'b1;
            return res;
        end
        locate_neighbours(req.column, req.row, c0, c1, r0, r1, fx, fy);
        sum = (256 - fx) * (256 - fy) * 32'(frame_model[r0 * MAX_WIDTH + c0])
            + fx * (256 - fy) * 32'(frame_model[r0 * MAX_WIDTH + c1])
            + (256 - fx) * fy * 32'(frame_model[r1 * MAX_WIDTH + c0])
            + fx * fy * 32'(frame_model[r1 * MAX_WIDTH + c1]);
        res.pixel_out = PIX_W'(sum >> 16);
        return res;
    endfunction

    function automatic void queue_write(int unsigned col, int unsigned row,
                                        logic [PIX_W-1:0] pix);
        t_in_item op_item;
        op_item.op       = OP_WRITE;
        op_item.column   = COORD_W'(col);
        op_item.row      = COORD_W'(row);
        op_item.pixel_in = pix;
        ops_to_send.push_back(op_item);
        written_map[row * MAX_WIDTH + col] = 1'b1;
        items_queued++;
    endfunction

    // Request a pixel; any neighbour not yet loaded gets a random value first
    function automatic void queue_request(int unsigned col, int unsigned row);
        t_in_item    op_item;
        int unsigned c0, c1, r0, r1, fx, fy, c, r;
        if (col < 32'(out_w) && row < 32'(out_h)) begin
            locate_neighbours(COORD_W'(col), COORD_W'(row), c0, c1, r0, r1, fx, fy);
            for (int k = 0; k < 4; k++) begin
                c = k[0] ? c1 : c0;
                r = k[1] ? r1 : r0;
                if (!written_map[r * MAX_WIDTH + c])
                    queue_write(c, r, PIX_W'($urandom));
            end
        end
        op_item.op       = OP_REQUEST;
        op_item.column   = COORD_W'(col);
        op_item.row      = COORD_W'(row);
        op_item.pixel_in = PIX_W'($urandom);
        ops_to_send.push_back(op_item);
        items_queued++;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dimension();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIM_W'(MAX_WIDTH);
            2:       return DIM_W'($urandom_range(513, 1023));
            3:       return DIM_W'($urandom_range(1, 512));
            default: return DIM_W'($urandom_range(1, 24));
        endcase
    endfunction

    // Mostly the true source/output ratio, sometimes the extremes or noise
    function automatic logic [SCALE_W-1:0] pick_scale(logic [DIM_W-1:0] s, logic [DIM_W-1:0] o);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SCALE_W'(1 << 25);
            2:       return SCALE_W'($urandom);
            default: return SCALE_W'((effective_size(s, MAX_WIDTH) << 16)
                                     / effective_size(o, MAX_WIDTH));
        endcase
    endfunction

    task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_SRC_W:   src_w   = value[DIM_W-1:0];
            CFG_SRC_H:   src_h   = value[DIM_W-1:0];
            CFG_OUT_W:   out_w   = value[DIM_W-1:0];
            CFG_OUT_H:   out_h   = value[DIM_W-1:0];
            CFG_SCALE_X: scale_x = value[SCALE_W-1:0];
            CFG_SCALE_Y: scale_y = value[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // Size registers sometimes carry junk above bit 9, which must be dropped
    task automatic configure(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                             logic [DIM_W-1:0] ow, logic [DIM_W-1:0] oh,
                             logic [SCALE_W-1:0] kx, logic [SCALE_W-1:0] ky);
        logic [CFG_W-DIM_W-1:0] pad;
        pad = ($urandom_range(0, 3) == 0) ? (CFG_W-DIM_W)'($urandom) : '0;
        write_register(CFG_SRC_W, {pad, sw});
        write_register(CFG_SRC_H, {pad, sh});
        write_register(CFG_OUT_W, {pad, ow});
        write_register(CFG_OUT_H, {pad, oh});
        write_register(CFG_SCALE_X, kx);
        write_register(CFG_SCALE_Y, ky);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait for every queued transaction and result, then let the last write land
    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (ops_to_send.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Sender: offers queued transactions, predicts each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                if (in_data.op == OP_WRITE)
                    frame_model[in_data.row * MAX_WIDTH + in_data.column] = in_data.pixel_in;
                else
                    expected_pixels.push_back(interpolate(in_data));
                send_gap = $urandom_range(0, send_gap_max);
            end
            if (!(in_valid && in_stall)) begin
                if (send_gap > 0 || ops_to_send.size() == 0) begin
                    in_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end else begin
                    in_valid <= 1'b1;
                    in_data  <= ops_to_send.pop_front();
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item oldest;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: pixel_out %0d, out_of_range %0d",
                           out_data.pixel_out, out_data.out_of_range);
                    mismatch_count++;
                end else begin
                    oldest = expected_pixels.pop_front();
                    if (out_data.pixel_out !== oldest.pixel_out) begin
                        $error("pixel_out: expected %0d, actual %0d",
                               oldest.pixel_out, out_data.pixel_out);
                        mismatch_count++;
                    end
                    if (out_data.out_of_range !== oldest.out_of_range) begin
                        $error("out_of_range: expected %0d, actual %0d",
                               oldest.out_of_range, out_data.out_of_range);
                        mismatch_count++;
                    end
                end
                recv_gap = $urandom_range(0, recv_gap_max);
            end
            if (want_long_hold && !long_hold_done) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int unsigned      col, row, phase_end, phase;
        logic [DIM_W-1:0] sw, sh, ow, oh;
        phase = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: unit scale, corners, right and bottom edge clamping
        queue_write(0, 0, 8'hFF);
        queue_write(1, 0, 8'h00);
        queue_write(0, 1, 8'h80);
        queue_write(1, 1, 8'h01);
        queue_request(0, 0);
        queue_request(511, 511);
        queue_request(511, 0);
        queue_request(0, 511);
        wait_until_idle();

        // Source width of zero, oversized source height, zero vertical scale,
        // requests past the output size
        configure(10'd0, 10'd1023, 10'd3, 10'd2, 26'h18000, 26'd0);
        queue_request(2, 1);
        queue_request(3, 0);
        queue_request(0, 2);
        queue_request(511, 511);
        wait_until_idle();

        // Two-times upscale: half-pixel fractions, clamped at the last row and column
        configure(10'd8, 10'd8, 10'd16, 10'd16, 26'h8000, 26'h8000);
        queue_request(15, 15);
        queue_request(3, 5);
        wait_until_idle();

        // Largest horizontal scale factor, vertical scale of 2^25
        configure(10'd512, 10'd512, 10'd512, 10'd512, 26'h3FFFFFF, 26'h2000000);
        queue_request(511, 511);
        queue_request(1, 1);
        wait_until_idle();

        // Zero scale on both axes always samples the top-left pixel
        configure(10'd4, 10'd4, 10'd8, 10'd8, 26'd0, 26'd0);
        queue_request(7, 7);
        queue_request(5, 2);
        wait_until_idle();

        // Empty output frame: every request is out of range
        configure(10'd512, 10'd512, 10'd0, 10'd0, RST_SCALE, RST_SCALE);
        queue_request(0, 0);
        wait_until_idle();

        // Random phases, each under its own settings and idling pattern
        while (items_queued < ITEM_TARGET) begin
            phase++;
            send_gap_max = (phase % 3 == 0) ? 0 : 4;
            recv_gap_max = (phase % 4 == 1) ? 0 : 4;
            sw = pick_dimension();
            sh = pick_dimension();
            ow = pick_dimension();
            oh = pick_dimension();
            configure(sw, sh, ow, oh, pick_scale(sw, ow), pick_scale(sh, oh));
            phase_end = items_queued + PHASE_ITEMS;
            while (items_queued < phase_end) begin
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 3) != 0) begin
                        col = $urandom_range(0, effective_size(src_w, MAX_WIDTH) - 1);
                        row = $urandom_range(0, effective_size(src_h, MAX_HEIGHT) - 1);
                    end else begin
                        col = $urandom_range(0, MAX_WIDTH - 1);
                        row = $urandom_range(0, MAX_HEIGHT - 1);
                    end
                    queue_write(col, row, PIX_W'($urandom));
                end else begin
                    if (out_w != 0 && out_h != 0 && $urandom_range(0, 4) != 0) begin
                        col = $urandom_range(0, effective_size(out_w, MAX_WIDTH) - 1);
                        row = $urandom_range(0, effective_size(out_h, MAX_HEIGHT) - 1);
                    end else begin
                        col = $urandom_range(0, MAX_WIDTH - 1);
                        row = $urandom_range(0, MAX_HEIGHT - 1);
                    end
                    queue_request(col, row);
                end
            end
            // One long receiver hold-off so the block backs up into its input
            if (phase == 2)
                want_long_hold = 1'b1;
            wait_until_idle();
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
